@@ hw/rtl/char_lcd_nibble_write_sequencer_assert.svh @@
// Assertion helpers for the LCD nibble sequencer.
// All checks run on clk and are off while rst_n is low.
`ifndef CHAR_LCD_NIBBLE_WRITE_SEQUENCER_ASSERT_SVH
`define CHAR_LCD_NIBBLE_WRITE_SEQUENCER_ASSERT_SVH

// Same-cycle implication.
`define CLNWS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define CLNWS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/clnws_pkg.sv @@
`timescale 1ns / 1ps

package clnws_pkg;

  // Request kinds, carried on in_tuser
  typedef enum logic [1:0] {
    KIND_CMD  = 2'd0,
    KIND_DATA = 2'd1,
    KIND_DEC  = 2'd2,
    KIND_INIT = 2'd3
  } kind_t;

  localparam logic [15:0] PHASE_US    = 16'd100;
  localparam logic [15:0] CLEAR_US    = 16'd200;
  localparam logic [15:0] POWERUP_US  = 16'd50000;
  localparam logic [15:0] ACTIVATE_US = 16'd5000;
  localparam logic [7:0]  ASCII_ZERO  = 8'h30;
  localparam logic [4:0]  INIT_LAST   = 5'd22;

  // One pin phase of the power-up script
  typedef struct packed {
    logic        en;
    logic [3:0]  nib;
    logic [15:0] hold;
  } init_phase_t;

  // Powers of ten used as divisors for digit extraction
  function automatic logic [15:0] pow10(input logic [2:0] d);
    logic [15:0] p;
    unique case (d)
      3'd0:    p = 16'd1;
      3'd1:    p = 16'd10;
      3'd2:    p = 16'd100;
      3'd3:    p = 16'd1000;
      3'd4:    p = 16'd10000;
      default: p = 16'd1;
    endcase
    return p;
  endfunction

  // Rounded-up reciprocals: x / 10^d == (x * recip10(d)) >> recip_shift(d)
  // holds exactly for every 16-bit x
  function automatic logic [16:0] recip10(input logic [2:0] d);
    logic [16:0] r;
    unique case (d)
      3'd0:    r = 17'd65536;
      3'd1:    r = 17'd52429;
      3'd2:    r = 17'd83887;
      3'd3:    r = 17'd67109;
      3'd4:    r = 17'd107375;
      default: r = 17'd65536;
    endcase
    return r;
  endfunction

  function automatic logic [4:0] recip_shift(input logic [2:0] d);
    logic [4:0] s;
    unique case (d)
      3'd0:    s = 5'd16;
      3'd1:    s = 5'd19;
      3'd2:    s = 5'd23;
      3'd3:    s = 5'd26;
      3'd4:    s = 5'd30;
      default: s = 5'd16;
    endcase
    return s;
  endfunction

  // Power-up script: wait, activation pulse, then 0x28 0x08 0x01 0x06 0x0C
  function automatic init_phase_t init_phase(input logic [4:0] idx);
    init_phase_t ph;
    unique case (idx)
      5'd0:    ph = '{en: 1'b0, nib: 4'h0, hold: POWERUP_US};
      5'd1:    ph = '{en: 1'b1, nib: 4'h2, hold: 16'd0};
      5'd2:    ph = '{en: 1'b0, nib: 4'h2, hold: ACTIVATE_US};
      5'd3:    ph = '{en: 1'b1, nib: 4'h2, hold: PHASE_US};
      5'd4:    ph = '{en: 1'b0, nib: 4'h2, hold: PHASE_US};
      5'd5:    ph = '{en: 1'b1, nib: 4'h8, hold: PHASE_US};
      5'd6:    ph = '{en: 1'b0, nib: 4'h8, hold: PHASE_US};
      5'd7:    ph = '{en: 1'b1, nib: 4'h0, hold: PHASE_US};
      5'd8:    ph = '{en: 1'b0, nib: 4'h0, hold: PHASE_US};
      5'd9:    ph = '{en: 1'b1, nib: 4'h8, hold: PHASE_US};
      5'd10:   ph = '{en: 1'b0, nib: 4'h8, hold: PHASE_US};
      5'd11:   ph = '{en: 1'b1, nib: 4'h0, hold: PHASE_US};
      5'd12:   ph = '{en: 1'b0, nib: 4'h0, hold: PHASE_US};
      5'd13:   ph = '{en: 1'b1, nib: 4'h1, hold: PHASE_US};
      5'd14:   ph = '{en: 1'b0, nib: 4'h1, hold: CLEAR_US};
      5'd15:   ph = '{en: 1'b1, nib: 4'h0, hold: PHASE_US};
      5'd16:   ph = '{en: 1'b0, nib: 4'h0, hold: PHASE_US};
      5'd17:   ph = '{en: 1'b1, nib: 4'h6, hold: PHASE_US};
      5'd18:   ph = '{en: 1'b0, nib: 4'h6, hold: PHASE_US};
      5'd19:   ph = '{en: 1'b1, nib: 4'h0, hold: PHASE_US};
      5'd20:   ph = '{en: 1'b0, nib: 4'h0, hold: PHASE_US};
      5'd21:   ph = '{en: 1'b1, nib: 4'hC, hold: PHASE_US};
      5'd22:   ph = '{en: 1'b0, nib: 4'hC, hold: PHASE_US};
      default: ph = '{en: 1'b0, nib: 4'h0, hold: 16'd0};
    endcase
    return ph;
  endfunction

endpackage

@@ hw/rtl/char_lcd_nibble_write_sequencer.sv @@
`timescale 1ns / 1ps
// Phases are registered on out, one per cycle unless out_tready stalls. Command/data byte:
//   4 phases. Decimal: per digit a quotient, then a remainder step on the shared multiplier,
//   then 4 phases; a count below MAX_DIGITS adds one pre-reduction first. Power-up: 23
//   phases. One request at a time; next taken once back idle.
// Synchronous active-low reset returns the sequencer to idle with the output empty.
module char_lcd_nibble_write_sequencer #(
  parameter int MAX_DIGITS = 4
) (
  input  logic                    clk,
  input  logic                    rst_n,
  // in_tdata: byte_value[7:0], number_value[23:8], digit_count[26:24], zero fill
  input  logic [31:0]             in_tdata,
  // in_tuser: kind[1:0]
  input  logic [1:0]              in_tuser,
  input  logic                    in_tvalid,
  output logic                    in_tready,
  // out_tdata: reg_select[0], enable_level[1], bus_nibble[5:2], hold_us[21:6], zero fill
  output logic [23:0]             out_tdata,
  output logic                    out_tlast,
  output logic                    out_tvalid,
  input  logic                    out_tready
);
  import clnws_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_QUO  = 3'd1;
  localparam logic [2:0] ST_REM  = 3'd2;
  localparam logic [2:0] ST_EMIT = 3'd3;
  localparam logic [2:0] ST_INIT = 3'd4;

  localparam logic [2:0] MAX_D  = 3'(MAX_DIGITS);
  localparam logic [2:0] LEAD_D = 3'(MAX_DIGITS - 1);

  logic [2:0]  state_r, state_nxt;
  logic [15:0] quo_r, quo_nxt;
  logic [15:0] num_r, num_nxt;
  logic [2:0]  d_r, d_nxt;
  logic        pre_r, pre_nxt;
  logic [7:0]  byte_r, byte_nxt;
  logic        rs_r, rs_nxt;
  logic        last_byte_r, last_byte_nxt;
  logic [1:0]  ph_r, ph_nxt;
  logic [4:0]  idx_r, idx_nxt;

  logic        out_valid_r;
  logic [21:0] out_data_r;
  logic        out_last_r;

  logic        in_fire;
  logic [1:0]  in_kind;
  logic [7:0]  in_byte;
  logic [15:0] in_num;
  logic [2:0]  in_cnt;

  logic [2:0]  pw;
  logic [15:0] mul_a;
  logic [16:0] mul_b;
  logic [32:0] mul_p;
  logic [15:0] quo_calc;
  logic [15:0] rem_calc;

  logic        slot_free;
  logic        phase_vld;
  logic        advance;
  init_phase_t ip;
  logic        ph_en;
  logic [3:0]  ph_nib;
  logic [15:0] ph_hold;
  logic        ph_last;

  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign in_kind   = in_tuser;
  assign in_byte   = in_tdata[7:0];
  assign in_num    = in_tdata[23:8];
  assign in_cnt    = in_tdata[26:24];

  // Shared multiplier: reciprocal for the quotient, then power of ten for the remainder
  assign pw       = pre_r ? (d_r + 3'd1) : d_r;
  assign mul_a    = (state_r == ST_REM) ? quo_r : num_r;
  assign mul_b    = (state_r == ST_REM) ? {1'b0, pow10(pw)} : recip10(pw);
  assign mul_p    = {17'd0, mul_a} * {16'd0, mul_b};
  assign quo_calc = 16'(mul_p >> recip_shift(pw));
  assign rem_calc = num_r - mul_p[15:0];

  // Phase generation for the current request
  assign slot_free = !out_valid_r || out_tready;
  assign phase_vld = (state_r == ST_EMIT) || (state_r == ST_INIT);
  assign advance   = slot_free && phase_vld;
  assign ip        = init_phase(idx_r);

  always_comb begin
    if (state_r == ST_INIT) begin
      ph_en   = ip.en;
      ph_nib  = ip.nib;
      ph_hold = ip.hold;
      ph_last = (idx_r == INIT_LAST);
    end else begin
      ph_en   = ~ph_r[0];
      ph_nib  = ph_r[1] ? byte_r[3:0] : byte_r[7:4];
      ph_hold = PHASE_US;
      ph_last = last_byte_r && (ph_r == 2'd3);
    end
  end

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    quo_nxt       = quo_r;
    num_nxt       = num_r;
    d_nxt         = d_r;
    pre_nxt       = pre_r;
    byte_nxt      = byte_r;
    rs_nxt        = rs_r;
    last_byte_nxt = last_byte_r;
    ph_nxt        = ph_r;
    idx_nxt       = idx_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          priority if (in_kind == KIND_CMD || in_kind == KIND_DATA) begin
            byte_nxt      = in_byte;
            rs_nxt        = in_kind[0];
            last_byte_nxt = 1'b1;
            ph_nxt        = 2'd0;
            state_nxt     = ST_EMIT;
          end else if (in_kind == KIND_DEC) begin
            if (in_cnt != 3'd0 && in_cnt <= MAX_D) begin
              num_nxt   = in_num;
              d_nxt     = in_cnt - 3'd1;
              // keep only the printed digits first: num mod 10^count
              pre_nxt   = (in_cnt != MAX_D);
              state_nxt = ST_QUO;
            end
          end else begin
            idx_nxt   = 5'd0;
            state_nxt = ST_INIT;
          end
        end
      end
      ST_QUO: begin
        quo_nxt   = quo_calc;
        state_nxt = ST_REM;
      end
      ST_REM: begin
        num_nxt = rem_calc;
        if (pre_r) begin
          pre_nxt   = 1'b0;
          state_nxt = ST_QUO;
        end else begin
          // leading digit wraps in 8 bits, lower ones are already below ten
          byte_nxt      = quo_r[7:0] + ASCII_ZERO;
          rs_nxt        = 1'b1;
          last_byte_nxt = (d_r == 3'd0);
          ph_nxt        = 2'd0;
          state_nxt     = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (advance) begin
          ph_nxt = ph_r + 2'd1;
          if (ph_r == 2'd3) begin
            if (last_byte_r) begin
              state_nxt = ST_IDLE;
            end else begin
              d_nxt     = d_r - 3'd1;
              state_nxt = ST_QUO;
            end
          end
        end
      end
      ST_INIT: begin
        if (advance) begin
          idx_nxt = idx_r + 5'd1;
          if (idx_r == INIT_LAST) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (slot_free) begin
        out_valid_r <= phase_vld;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    quo_r       <= quo_nxt;
    num_r       <= num_nxt;
    d_r         <= d_nxt;
    pre_r       <= pre_nxt;
    byte_r      <= byte_nxt;
    rs_r        <= rs_nxt;
    last_byte_r <= last_byte_nxt;
    ph_r        <= ph_nxt;
    idx_r       <= idx_nxt;
    if (advance) begin
      out_data_r <= {ph_hold, ph_nib, ph_en, (state_r == ST_INIT) ? 1'b0 : rs_r};
      out_last_r <= ph_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_data_r};
  assign out_tlast  = out_last_r;

`include "char_lcd_nibble_write_sequencer_assert.svh"

  `CLNWS_ASSERT_NEXT(a_quo_then_rem, state_r == ST_QUO, state_r == ST_REM, "no remainder step")
  `CLNWS_ASSERT_NOW(a_rem_fits, state_r == ST_REM, mul_p[32:16] == 17'd0 && mul_p[15:0] <= num_r, "remainder borrow")
  `CLNWS_ASSERT_NOW(a_digit_range, state_r == ST_REM && !pre_r && d_r != LEAD_D, quo_r < 16'd10, "digit over nine")
  `CLNWS_ASSERT_NOW(a_last_enable_low, out_tvalid && out_tlast, !out_tdata[1], "final phase must drop enable")
  `CLNWS_ASSERT_NEXT(a_byte_emit, in_fire && (in_tuser == KIND_CMD || in_tuser == KIND_DATA), state_r == ST_EMIT, "byte request not emitting")

endmodule
